[hdl/dcmf_pkg.sv]
// Shared constants, types and helpers of the dark channel minimum filter.
// Used by dcmf_cell and dark_channel_min_filter.
`timescale 1ns / 1ps
`default_nettype none
package dcmf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 7;
   localparam int HEIGHT_LIMIT   = 4096;

   localparam int PIX_W    = 8;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int RAD_W    = 3;
   localparam int ROW_W    = 13;
   localparam int CSR_W    = 13;
   localparam int IDX_W    = 2;
   localparam int CMP_W    = 16;

   localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

   typedef struct packed {
      logic             shift;
      logic [RAD_W-1:0] radius;
   } win_ctl_type;

   function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      min8 = (a < b) ? a : b;
   endfunction

endpackage
`default_nettype wire

[hdl/dark_channel_min_filter.sv]
// Top level of the dark channel minimum filter: line store banks, vertical minimum,
// horizontal cell chain and output register. Depends on dcmf_pkg, dcmf_bank, dcmf_cell.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one item per clock cycle unless the output stalls, a rate set by
// the single write and single read of each line store bank per cycle; results pass
// the read, chain and output registers. Each row of the frame goes into one of
// 2*MAX_RADIUS+2 banks, every column minimum is read from all banks at once, and a
// chain of 2*MAX_RADIUS+1 cells forms the horizontal window. Results trail the input
// by radius rows plus radius pixels; after the last pixel, flush items release the
// remaining results, and tlast marks the final one. The line store is not cleared.
module dark_channel_min_filter
   import dcmf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [23:0]      req_tdata,   // red, green, blue
   input  wire logic             req_tuser,   // opcode
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [7:0]       rsp_tdata,   // dark_value
   output logic                  rsp_tlast,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int RING   = 2 * MAX_RADIUS + 2;
   localparam int BANK_W = $clog2(RING);
   localparam int CELLS  = 2 * MAX_RADIUS + 1;
   localparam int VLV    = $clog2(RING);
   localparam int VNP    = 1 << VLV;
   localparam int HLV    = $clog2(CELLS);
   localparam int HNP    = 1 << HLV;
   localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

   // Configuration.
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [RAD_W-1:0]    radius_ff, radius_in;
   logic                restart_cfg;
   logic [RAD_W-1:0]    r_eff;

   // Position counters.
   logic [COL_W-1:0]  pcol_ff, pcol_in;
   logic [ROW_W-1:0]  prow_ff, prow_in;
   logic [BANK_W-1:0] wbank_ff, wbank_in;
   logic              complete_ff, complete_in;
   logic [COL_W-1:0]  ox_ff, ox_in;
   logic [ROW_W-1:0]  oy_ff, oy_in;

   // Accept stage.
   logic             en, acc, op_pix, adv, wr, emit, last, past_lag, row_end;
   logic [PIX_W-1:0] pix_min;
   logic [RING-1:0]  mask;

   // Read stage.
   logic              b_adv_ff, b_emit_ff, b_last_ff;
   logic [COL_W-1:0]  b_ox_ff, b_tag_ff;
   logic [RING-1:0]  b_mask_ff;
   logic              b_blank_ff, b_wr_ff;
   logic [BANK_W-1:0] b_wbank_ff;
   logic [PIX_W-1:0]  b_min_ff;
   logic [PIX_W-1:0]  rd_val [RING];
   logic [PIX_W-1:0]  vt [VLV+1][VNP];
   logic [PIX_W-1:0]  vmin;

   // Chain stage.
   logic             c_emit_ff, c_last_ff;
   logic [COL_W-1:0] c_ox_ff;
   win_ctl_type      ctl;
   logic [PIX_W-1:0] cell_val [CELLS];
   logic [COL_W-1:0] cell_tag [CELLS];
   logic [PIX_W-1:0] cell_term [CELLS];
   logic [PIX_W-1:0] ht [HLV+1][HNP];

   // Output register.
   logic             rsp_tvalid_ff;
   logic [PIX_W-1:0] rsp_tdata_ff;
   logic             rsp_tlast_ff;

   // ---------------- configuration ----------------
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      radius_in   = radius_ff;
      restart_cfg = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_WIDTH: begin
               restart_cfg = 1'b1;
               if (csr_wdata[WIDTH_W-1:0] == '0) begin
                  width_in = WIDTH_W'(1);
               end else if (CMP_W'(csr_wdata[WIDTH_W-1:0]) > CMP_W'(MAX_WIDTH)) begin
                  width_in = WIDTH_W'(MAX_WIDTH);
               end else begin
                  width_in = csr_wdata[WIDTH_W-1:0];
               end
            end
            REG_HEIGHT: begin
               restart_cfg = 1'b1;
               if (csr_wdata[HEIGHT_W-1:0] == '0) begin
                  height_in = HEIGHT_W'(1);
               end else if (CMP_W'(csr_wdata[HEIGHT_W-1:0]) > CMP_W'(HEIGHT_LIMIT)) begin
                  height_in = HEIGHT_W'(HEIGHT_LIMIT);
               end else begin
                  height_in = csr_wdata[HEIGHT_W-1:0];
               end
            end
            REG_RADIUS: begin
               restart_cfg = 1'b1;
               if (CMP_W'(csr_wdata[RAD_W-1:0]) > CMP_W'(MAX_RADIUS)) begin
                  radius_in = RAD_W'(MAX_RADIUS);
               end else begin
                  radius_in = csr_wdata[RAD_W-1:0];
               end
            end
            default: begin
               restart_cfg = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      r_eff = radius_ff;
      if (CMP_W'(r_eff) > CMP_W'(width_ff) - CMP_W'(1)) begin
         r_eff = RAD_W'(width_ff - WIDTH_W'(1));
      end
      if (CMP_W'(r_eff) > CMP_W'(height_ff) - CMP_W'(1)) begin
         r_eff = RAD_W'(height_ff - HEIGHT_W'(1));
      end
   end

   // ---------------- accept stage ----------------
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign acc        = req_tvalid && en;
   assign op_pix     = (req_tuser == OP_PIXEL);
   assign adv        = acc && (op_pix || complete_ff);
   assign wr         = acc && op_pix && !complete_ff;
   assign past_lag   = (CMP_W'(prow_ff) > CMP_W'(r_eff)) ||
                       ((CMP_W'(prow_ff) == CMP_W'(r_eff)) &&
                        (CMP_W'(pcol_ff) >= CMP_W'(r_eff)));
   assign emit       = adv && past_lag;
   assign last       = (CMP_W'(oy_ff) == CMP_W'(height_ff) - CMP_W'(1)) &&
                       (CMP_W'(ox_ff) == CMP_W'(width_ff) - CMP_W'(1));
   assign row_end    = (CMP_W'(pcol_ff) == CMP_W'(width_ff) - CMP_W'(1));
   assign pix_min    = min8(min8(req_tdata[7:0], req_tdata[15:8]), req_tdata[23:16]);

   // A bank takes part when its row lies inside the window and inside the frame.
   always_comb begin
      int          ring_gap;
      logic [CMP_W-1:0] dd;
      for (int b = 0; b < RING; b++) begin
         ring_gap = (int'(wbank_ff) >= b) ? (int'(wbank_ff) - b) :
                                            (int'(wbank_ff) + RING - b);
         dd   = CMP_W'(ring_gap);
         mask[b] = (dd <= CMP_W'(2) * CMP_W'(r_eff)) && (dd <= CMP_W'(prow_ff)) &&
                   (CMP_W'(prow_ff) <= dd + CMP_W'(height_ff) - CMP_W'(1));
      end
   end

   always_comb begin
      pcol_in     = pcol_ff;
      prow_in     = prow_ff;
      wbank_in    = wbank_ff;
      complete_in = complete_ff;
      ox_in       = ox_ff;
      oy_in       = oy_ff;
      if (adv) begin
         if (row_end) begin
            pcol_in  = '0;
            prow_in  = prow_ff + ROW_W'(1);
            wbank_in = (int'(wbank_ff) == RING - 1) ? '0 : wbank_ff + BANK_W'(1);
            if (wr && (CMP_W'(prow_ff) == CMP_W'(height_ff) - CMP_W'(1))) begin
               complete_in = 1'b1;
            end
         end else begin
            pcol_in = pcol_ff + COL_W'(1);
         end
      end
      if (emit) begin
         if (CMP_W'(ox_ff) == CMP_W'(width_ff) - CMP_W'(1)) begin
            ox_in = '0;
            oy_in = oy_ff + ROW_W'(1);
         end else begin
            ox_in = ox_ff + COL_W'(1);
         end
      end
      if ((emit && last) || restart_cfg) begin
         pcol_in     = '0;
         prow_in     = '0;
         wbank_in    = '0;
         complete_in = 1'b0;
         ox_in       = '0;
         oy_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_W'(WIDTH_RST);
         height_ff   <= HEIGHT_W'(1024);
         radius_ff   <= RAD_W'(2);
         pcol_ff     <= '0;
         prow_ff     <= '0;
         wbank_ff    <= '0;
         complete_ff <= 1'b0;
         ox_ff       <= '0;
         oy_ff       <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         radius_ff   <= radius_in;
         pcol_ff     <= pcol_in;
         prow_ff     <= prow_in;
         wbank_ff    <= wbank_in;
         complete_ff <= complete_in;
         ox_ff       <= ox_in;
         oy_ff       <= oy_in;
      end
   end

   // ---------------- line store ----------------
   for (genvar b = 0; b < RING; b++) begin : g_bank
      dcmf_bank #(
         .DEPTH  (MAX_WIDTH),
         .ADDR_W (COL_W)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr && (int'(wbank_ff) == b)),
         .wr_addr (pcol_ff),
         .wr_data (pix_min),
         .rd_en   (en),
         .rd_addr (pcol_ff),
         .rd_data (rd_val[b])
      );
   end

   // ---------------- read stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_adv_ff  <= 1'b0;
         b_emit_ff <= 1'b0;
         b_last_ff <= 1'b0;
      end else if (en) begin
         b_adv_ff  <= adv;
         b_emit_ff <= emit;
         b_last_ff <= emit && last;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ox_ff    <= ox_ff;
         b_tag_ff   <= pcol_ff;
         b_mask_ff  <= mask;
         b_blank_ff <= (CMP_W'(prow_ff) < CMP_W'(r_eff));
         b_wr_ff    <= wr;
         b_wbank_ff <= wbank_ff;
         b_min_ff   <= pix_min;
      end
   end

   always_comb begin
      for (int l = 0; l <= VLV; l++) begin
         for (int i = 0; i < VNP; i++) begin
            vt[l][i] = PIX_MAX;
         end
      end
      for (int i = 0; i < RING; i++) begin
         if (!b_mask_ff[i]) begin
            vt[0][i] = PIX_MAX;
         end else if (b_wr_ff && (int'(b_wbank_ff) == i)) begin
            vt[0][i] = b_min_ff;
         end else begin
            vt[0][i] = rd_val[i];
         end
      end
      for (int l = 1; l <= VLV; l++) begin
         for (int i = 0; i < (VNP >> l); i++) begin
            vt[l][i] = min8(vt[l-1][2*i], vt[l-1][2*i+1]);
         end
      end
   end

   assign vmin = b_blank_ff ? PIX_MAX : vt[VLV][0];

   // ---------------- chain stage ----------------
   assign ctl.shift  = en && b_adv_ff;
   assign ctl.radius = r_eff;

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      dcmf_cell #(
         .POS   (j),
         .COL_W (COL_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .ox        (c_ox_ff),
         .value_in  ((j == 0) ? vmin : cell_val[(j == 0) ? 0 : j - 1]),
         .tag_in    ((j == 0) ? b_tag_ff : cell_tag[(j == 0) ? 0 : j - 1]),
         .value_out (cell_val[j]),
         .tag_out   (cell_tag[j]),
         .term      (cell_term[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_emit_ff <= 1'b0;
         c_last_ff <= 1'b0;
      end else if (en) begin
         c_emit_ff <= b_emit_ff;
         c_last_ff <= b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ox_ff <= b_ox_ff;
      end
   end

   always_comb begin
      for (int l = 0; l <= HLV; l++) begin
         for (int i = 0; i < HNP; i++) begin
            ht[l][i] = PIX_MAX;
         end
      end
      for (int i = 0; i < CELLS; i++) begin
         ht[0][i] = cell_term[i];
      end
      for (int l = 1; l <= HLV; l++) begin
         for (int i = 0; i < (HNP >> l); i++) begin
            ht[l][i] = min8(ht[l-1][2*i], ht[l-1][2*i+1]);
         end
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= c_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= ht[HLV][0];
         rsp_tlast_ff <= c_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   a_emit_advances: assert property (@(posedge clock) disable iff (reset)
      b_emit_ff |-> b_adv_ff)
      else $error("result scheduled without a chain shift");

   a_complete_row: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> (CMP_W'(prow_ff) >= CMP_W'(height_ff)))
      else $error("input complete before the last row");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> (ox_ff == '0 && oy_ff == '0 && !complete_ff && prow_ff == '0))
      else $error("frame end did not restart the counters");

   a_ox_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(ox_ff) < CMP_W'(width_ff))
      else $error("output column beyond the row");
`endif

endmodule
`default_nettype wire

[hdl/dcmf_bank.sv]
// One row bank of the line store: a simple dual-port memory with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dcmf_bank #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/dcmf_cell.sv]
// One cell of the horizontal window chain: holds a column minimum and its column.
// Depends on dcmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcmf_cell
   import dcmf_pkg::*;
#(
   parameter int POS   = 0,
   parameter int COL_W = 10
) (
   input  wire logic              clock,
   input  wire win_ctl_type       ctl,
   input  wire logic [COL_W-1:0]  ox,
   input  wire logic [PIX_W-1:0]  value_in,
   input  wire logic [COL_W-1:0]  tag_in,
   output logic      [PIX_W-1:0]  value_out,
   output logic      [COL_W-1:0]  tag_out,
   output logic      [PIX_W-1:0]  term
);

   logic [PIX_W-1:0] value_ff;
   logic [COL_W-1:0] tag_ff;
   logic             in_window;
   int               rad;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         value_ff <= value_in;
         tag_ff   <= tag_in;
      end
   end

   // A cell ahead of the center counts only while still in the same row (larger
   // column); a cell behind it only when its column is smaller.
   always_comb begin
      rad = int'(ctl.radius);
      if (POS < rad) begin
         in_window = (tag_ff > ox);
      end else if (POS == rad) begin
         in_window = 1'b1;
      end else if (POS <= 2 * rad) begin
         in_window = (tag_ff < ox);
      end else begin
         in_window = 1'b0;
      end
   end

   assign value_out = value_ff;
   assign tag_out   = tag_ff;
   assign term      = in_window ? value_ff : PIX_MAX;

endmodule
`default_nettype wire
